@@ hdl/crb_pkg.sv @@
// Shared types and constants for the crop and box-average downscaler.
`default_nettype none
package crb_pkg;

    localparam int NUM_CH    = 4;
    localparam int CH_W      = 8;
    localparam int SUM_W     = 22;
    localparam int POS_W     = 13;
    localparam int DIM_W     = 14;
    localparam int LVL_W     = 3;
    localparam int MASK_W    = 7;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIM_W-1:0] MAX_FRAME_HEIGHT = 14'd8192;
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 14'd1920;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 14'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_REGION_ENABLE = 3'd2,
        CFG_CROP_X        = 3'd3,
        CFG_CROP_Y        = 3'd4,
        CFG_CROP_W        = 3'd5,
        CFG_CROP_H        = 3'd6,
        CFG_SCALE_LEVEL   = 3'd7
    } cfg_reg_t;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;
    typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;

    typedef struct packed {
        logic              valid;
        logic [DIM_W-1:0]  fw;
        logic [DIM_W-1:0]  fh;
        logic [POS_W-1:0]  ox;
        logic [POS_W-1:0]  oy;
        logic [DIM_W-1:0]  dw;
        logic [DIM_W-1:0]  dh;
        logic [DIM_W-1:0]  dw_m1;
        logic [DIM_W-1:0]  dh_m1;
        logic [LVL_W-1:0]  lvl;
        logic [MASK_W-1:0] mask;
    } geom_t;

    localparam geom_t GEOM_RST = '{
        valid: 1'b1,
        fw:    RST_FRAME_WIDTH,
        fh:    RST_FRAME_HEIGHT,
        ox:    '0,
        oy:    '0,
        dw:    RST_FRAME_WIDTH,
        dh:    RST_FRAME_HEIGHT,
        dw_m1: RST_FRAME_WIDTH - 14'd1,
        dh_m1: RST_FRAME_HEIGHT - 14'd1,
        lvl:   '0,
        mask:  '0
    };

    typedef struct packed {
        logic             do_write;
        logic             do_out;
        logic             first_row;
        logic             last;
        logic [LVL_W-1:0] lvl;
        logic [POS_W-1:0] bx;
        sum_vec_t         sums;
    } item_t;

endpackage
`default_nettype wire

@@ hdl/crb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module crb_ram #(
    parameter int WIDTH = 88,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/crb_geom.sv @@
// Configuration registers and registered crop/block geometry derived from them.
`default_nettype none
module crb_geom
    import crb_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 8192,
    parameter int MAX_SCALE_LEVEL = 7
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output geom_t                     geom
);

    localparam logic [DIM_W-1:0] MaxW   = DIM_W'(MAX_FRAME_WIDTH);
    localparam logic [LVL_W-1:0] MaxLvl = LVL_W'(MAX_SCALE_LEVEL);

    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic             region_enable_reg;
    logic [DIM_W-1:0] crop_x_reg, crop_y_reg, crop_w_reg, crop_h_reg;
    logic [LVL_W-1:0] scale_level_reg;

    // first level: clamped frame sizes and origin, raw crop sizes
    logic [DIM_W-1:0] fw_a_reg, fh_a_reg, rw_a_reg, rh_a_reg;
    logic [POS_W-1:0] rx_a_reg, ry_a_reg;
    logic [LVL_W-1:0] lvl_a_reg;
    logic             en_a_reg;

    // second level: clipped region
    logic [DIM_W-1:0] fw_b_reg, fh_b_reg, ow_b_reg, oh_b_reg;
    logic [POS_W-1:0] ox_b_reg, oy_b_reg;
    logic [LVL_W-1:0] lvl_b_reg;
    logic             valid_b_reg;

    logic [DIM_W-1:0] ow_next, oh_next, dw_next, dh_next;
    logic [DIM_W:0]   xw_sum, yh_sum;
    logic             valid_next;
    geom_t            geom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            region_enable_reg <= 1'b0;
            crop_x_reg        <= '0;
            crop_y_reg        <= '0;
            crop_w_reg        <= '0;
            crop_h_reg        <= '0;
            scale_level_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata;
                CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata;
                CFG_REGION_ENABLE: region_enable_reg <= cfg_wdata[0];
                CFG_CROP_X:        crop_x_reg        <= cfg_wdata;
                CFG_CROP_Y:        crop_y_reg        <= cfg_wdata;
                CFG_CROP_W:        crop_w_reg        <= cfg_wdata;
                CFG_CROP_H:        crop_h_reg        <= cfg_wdata;
                CFG_SCALE_LEVEL:   scale_level_reg   <= cfg_wdata[LVL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_a_reg  <= RST_FRAME_WIDTH;
            fh_a_reg  <= RST_FRAME_HEIGHT;
            rw_a_reg  <= '0;
            rh_a_reg  <= '0;
            rx_a_reg  <= '0;
            ry_a_reg  <= '0;
            lvl_a_reg <= '0;
            en_a_reg  <= 1'b0;
        end else begin
            fw_a_reg  <= (frame_width_reg == '0) ? DIM_W'(1) :
                         (frame_width_reg > MaxW) ? MaxW : frame_width_reg;
            fh_a_reg  <= (frame_height_reg == '0) ? DIM_W'(1) :
                         (frame_height_reg > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT :
                         frame_height_reg;
            rw_a_reg  <= crop_w_reg;
            rh_a_reg  <= crop_h_reg;
            rx_a_reg  <= crop_x_reg[DIM_W-1] ? '0 : crop_x_reg[POS_W-1:0];
            ry_a_reg  <= crop_y_reg[DIM_W-1] ? '0 : crop_y_reg[POS_W-1:0];
            lvl_a_reg <= (scale_level_reg > MaxLvl) ? MaxLvl : scale_level_reg;
            en_a_reg  <= region_enable_reg;
        end
    end

    always_comb begin
        xw_sum     = {2'b00, rx_a_reg} + {1'b0, rw_a_reg};
        yh_sum     = {2'b00, ry_a_reg} + {1'b0, rh_a_reg};
        valid_next = !en_a_reg ||
                     (rw_a_reg != '0 && rh_a_reg != '0 &&
                      {1'b0, rx_a_reg} < fw_a_reg && {1'b0, ry_a_reg} < fh_a_reg);
        if (!en_a_reg) begin
            ow_next = fw_a_reg;
        end else if (xw_sum > {1'b0, fw_a_reg}) begin
            ow_next = fw_a_reg - {1'b0, rx_a_reg};
        end else begin
            ow_next = rw_a_reg;
        end
        if (!en_a_reg) begin
            oh_next = fh_a_reg;
        end else if (yh_sum > {1'b0, fh_a_reg}) begin
            oh_next = fh_a_reg - {1'b0, ry_a_reg};
        end else begin
            oh_next = rh_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_b_reg    <= RST_FRAME_WIDTH;
            fh_b_reg    <= RST_FRAME_HEIGHT;
            ow_b_reg    <= RST_FRAME_WIDTH;
            oh_b_reg    <= RST_FRAME_HEIGHT;
            ox_b_reg    <= '0;
            oy_b_reg    <= '0;
            lvl_b_reg   <= '0;
            valid_b_reg <= 1'b1;
        end else begin
            fw_b_reg    <= fw_a_reg;
            fh_b_reg    <= fh_a_reg;
            ow_b_reg    <= ow_next;
            oh_b_reg    <= oh_next;
            ox_b_reg    <= en_a_reg ? rx_a_reg : '0;
            oy_b_reg    <= en_a_reg ? ry_a_reg : '0;
            lvl_b_reg   <= lvl_a_reg;
            valid_b_reg <= valid_next;
        end
    end

    assign dw_next = ow_b_reg >> lvl_b_reg;
    assign dh_next = oh_b_reg >> lvl_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg <= GEOM_RST;
        end else begin
            geom_reg.valid <= valid_b_reg;
            geom_reg.fw    <= fw_b_reg;
            geom_reg.fh    <= fh_b_reg;
            geom_reg.ox    <= ox_b_reg;
            geom_reg.oy    <= oy_b_reg;
            geom_reg.dw    <= dw_next;
            geom_reg.dh    <= dh_next;
            geom_reg.dw_m1 <= dw_next - DIM_W'(1);
            geom_reg.dh_m1 <= dh_next - DIM_W'(1);
            geom_reg.lvl   <= lvl_b_reg;
            geom_reg.mask  <= MASK_W'((8'd1 << lvl_b_reg) - 8'd1);
        end
    end

    assign geom = geom_reg;

endmodule
`default_nettype wire

@@ hdl/crb_accum.sv @@
// Raster position tracking, block decode and per-channel block-row sums.
`default_nettype none
module crb_accum
    import crb_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  accept,
    input  wire logic  frame_start,
    input  wire pix_t  px,
    input  wire geom_t geom,
    output item_t      item
);

    logic [POS_W-1:0]  col_reg, row_reg, col_next, row_next;
    sum_vec_t          brs_reg, brs_next;
    logic [POS_W-1:0]  x, y, relx, rely, bx, by;
    logic [MASK_W-1:0] col_phase, row_phase;
    logic              in_block, start_col, end_col, last_row, x_wrap, y_wrap;

    always_comb begin
        x         = frame_start ? '0 : col_reg;
        y         = frame_start ? '0 : row_reg;
        relx      = x - geom.ox;
        rely      = y - geom.oy;
        bx        = relx >> geom.lvl;
        by        = rely >> geom.lvl;
        in_block  = geom.valid && x >= geom.ox && y >= geom.oy &&
                    {1'b0, bx} < geom.dw && {1'b0, by} < geom.dh;
        col_phase = relx[MASK_W-1:0] & geom.mask;
        row_phase = rely[MASK_W-1:0] & geom.mask;
        start_col = col_phase == '0;
        end_col   = col_phase == geom.mask;
        last_row  = row_phase == geom.mask;
        for (int c = 0; c < NUM_CH; c++) begin
            brs_next[c] = start_col ? SUM_W'(px[c]) : brs_reg[c] + SUM_W'(px[c]);
        end
        x_wrap   = ({1'b0, x} + DIM_W'(1)) >= geom.fw;
        y_wrap   = ({1'b0, y} + DIM_W'(1)) >= geom.fh;
        col_next = x_wrap ? '0 : x + POS_W'(1);
        row_next = !x_wrap ? y : (y_wrap ? '0 : y + POS_W'(1));
    end

    always_comb begin
        item.do_write  = in_block && end_col;
        item.do_out    = in_block && end_col && last_row;
        item.first_row = row_phase == '0;
        item.last      = {1'b0, bx} == geom.dw_m1 && {1'b0, by} == geom.dh_m1;
        item.lvl       = geom.lvl;
        item.bx        = bx;
        item.sums      = brs_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            brs_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_block) begin
                brs_reg <= brs_next;
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/crop_box_downscale_core.sv @@
// Top level: crop and power-of-two box-average downscaler for 4x8-bit pixels.
// Output: the closing input pixel passes the stage-one register, then the output register.
// Throughput: 1 pixel per cycle unless the output stalls; the column-sum RAM does one read
// and one write per cycle. Configuration passes crb_geom's registers to reach the datapath.
// Reset (synchronous, aresetn low): registers to defaults, positions and row sums to zero.
// The column-sum RAM is not cleared; each entry is written in a block's first row.
`default_nettype none
module crop_box_downscale_core
    import crb_pkg::*;
#(
    parameter int MAX_FRAME_WIDTH = 8192,
    parameter int MAX_SCALE_LEVEL = 7
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [NUM_CH*CH_W-1:0]      s_tdata,   // ch0, ch1, ch2, ch3
    input  wire logic                        s_tuser,   // frame_start
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [NUM_CH*CH_W-1:0]      m_tdata,   // out_ch0, out_ch1, out_ch2, out_ch3
    output logic                             m_tlast,
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_wdata
);

    localparam int ColDepth = MAX_FRAME_WIDTH / 2;
    localparam int AddrW    = $clog2(ColDepth);
    localparam int RamW     = NUM_CH * SUM_W;

    geom_t                 geom;
    item_t                 item_in, s1_item_reg;
    logic                  s1_valid_reg, s1_leave, s_accept;
    logic                  fwd_hit_reg;
    sum_vec_t              fwd_data_reg, col_old, col_new;
    logic [RamW-1:0]       ram_rdata;
    logic                  wr_en;
    logic [AddrW-1:0]      waddr, raddr;
    logic                  m_tvalid_reg, m_tlast_reg;
    logic [NUM_CH*CH_W-1:0] m_tdata_reg, m_tdata_next;
    logic [SUM_W-1:0]      shifted;

    crb_geom #(
        .MAX_FRAME_WIDTH (MAX_FRAME_WIDTH),
        .MAX_SCALE_LEVEL (MAX_SCALE_LEVEL)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .geom      (geom)
    );

    crb_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .frame_start (s_tuser),
        .px          (pix_t'(s_tdata)),
        .geom        (geom),
        .item        (item_in)
    );

    crb_ram #(
        .WIDTH (RamW),
        .DEPTH (ColDepth)
    ) u_colsum_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (col_new),
        .re    (s_accept),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign s1_leave = s1_valid_reg &&
                      (!s1_item_reg.do_out || !m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_leave;
    assign s_accept = s_tvalid && s_tready;

    assign wr_en = s1_leave && s1_item_reg.do_write;
    assign waddr = s1_item_reg.bx[AddrW-1:0];
    assign raddr = item_in.bx[AddrW-1:0];

    // write in flight to the entry being read: take the new sum, not the RAM's old one
    assign col_old = fwd_hit_reg ? fwd_data_reg : sum_vec_t'(ram_rdata);

    always_comb begin
        shifted = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            col_new[c] = s1_item_reg.first_row ? s1_item_reg.sums[c] :
                         col_old[c] + s1_item_reg.sums[c];
        end
        for (int c = 0; c < NUM_CH; c++) begin
            shifted = col_new[c] >> {s1_item_reg.lvl, 1'b0};
            m_tdata_next[c*CH_W +: CH_W] = shifted[CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && waddr == raddr;
            end else if (s1_leave) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg  <= item_in;
            fwd_data_reg <= col_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_leave && s1_item_reg.do_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_leave && s1_item_reg.do_out) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= s1_item_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_item_reg.do_out && m_tvalid_reg && !m_tready |-> !s_tready)
        else $error("input taken while a finished pixel cannot move to the output");

    a_forward_on_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && wr_en && waddr == raddr |=> fwd_hit_reg)
        else $error("read of an entry being written was not forwarded");

    a_out_implies_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_item_reg.do_out |-> s1_item_reg.do_write)
        else $error("output pixel without a column-sum update");

endmodule
`default_nettype wire
